>>> hdl/ple_pkg.sv
// Shared constants, codes and types for the positional list engine.
`timescale 1ns / 1ps

package ple_pkg;

	localparam int CAPACITY = 32;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int VAL_W    = 32;
	localparam int IDX_W    = 6;
	localparam int POS_W    = 8;
	localparam int ACT_W    = 3;
	localparam int ST_W     = 3;

	typedef enum logic [ACT_W-1:0] {
		A_INS_HEAD = 3'd0,
		A_INS_TAIL = 3'd1,
		A_INS_AT   = 3'd2,
		A_DEL_HEAD = 3'd3,
		A_DEL_TAIL = 3'd4,
		A_DEL_AT   = 3'd5,
		A_READ_ALL = 3'd6
	} action_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK      = 3'd0,
		ST_EMPTY   = 3'd1,
		ST_INVALID = 3'd2,
		ST_RANGE   = 3'd3,
		ST_FULL    = 3'd4
	} status_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [VAL_W-1:0]  data;
	} ram_wr_t;

endpackage

>>> hdl/positional_list_engine.sv
// Top level of the positional list engine: decode, shift sequencer and result register.
`timescale 1ns / 1ps

// An ordered list of up to CAPACITY signed 32-bit words held in one on-chip
// memory. A command is taken at a clock edge with start high and busy low.
// Every command that gives a result gives it on the strobe, for exactly one
// cycle, with no way for the receiver to hold it off. A rejected command
// (full, empty, bad or out-of-range position) or a read-out of an empty list
// answers in the cycle after it is taken and leaves busy low, so the next
// command may follow at once; an unused action code is dropped silently.
// An insert at zero-based slot p moves the count-p words above it one place
// up, a delete at slot p moves the count-p-1 words above it one place down;
// the memory has one read and one write port, so one word moves per cycle
// and busy stays high until the shift has drained. The status result is
// strobed at the edge at which busy falls. A read-out streams one word per
// cycle, with last set on the final word; busy stays high until the final
// word has been read from the memory.
// The store needs no clearing pass: only words below the count are read.

module positional_list_engine (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [ple_pkg::ACT_W-1:0]   action,
	input  logic signed [ple_pkg::VAL_W-1:0] value,
	input  logic [ple_pkg::POS_W-1:0]   position,
	output logic                        strobe,
	output logic [ple_pkg::ST_W-1:0]    status,
	output logic signed [ple_pkg::VAL_W-1:0] value_res,
	output logic [ple_pkg::IDX_W-1:0]   index,
	output logic                        last
);
	import ple_pkg::*;

	// One-hot sequencer states.
	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_INS  = 4'b0010,
		S_DEL  = 4'b0100,
		S_DUMP = 4'b1000
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  count_q;   // words stored
	logic [CNT_W-1:0]  moves_q;   // memory reads still to issue
	logic [ADDR_W-1:0] rd_q;      // next read address
	logic [ADDR_W-1:0] slot_q;    // slot that receives the inserted word
	logic [VAL_W-1:0]  val_q;     // word to insert

	// Stage 1: a read issued last cycle, its data now on the RAM output.
	logic              pend_s1;
	logic [ADDR_W-1:0] addr_s1;

	logic [ST_W-1:0]   status_q;
	logic [VAL_W-1:0]  value_res_q;
	logic [IDX_W-1:0]  index_q;
	logic              last_q;
	logic              strobe_q;

	logic [VAL_W-1:0]  rd_data;
	ram_wr_t           wr;

	// Decode of the command on the input ports.
	logic              accept;
	logic              dec_emit;
	logic [ST_W-1:0]   dec_status;
	state_t            dec_state;
	logic [CNT_W-1:0]  dec_moves;
	logic [ADDR_W-1:0] dec_rd;
	logic [ADDR_W-1:0] dec_slot;
	logic [CNT_W-1:0]  ins_p;
	logic [CNT_W-1:0]  del_p;
	logic [POS_W-1:0]  pos_m1;
	logic              full;
	logic              empty;
	logic              pos_zero;
	logic              ins_range;
	logic              del_range;

	// Sequencer events.
	logic              issue;
	logic              done;
	logic              dump_out;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	assign full      = (count_q == CNT_W'(CAPACITY));
	assign empty     = (count_q == '0);
	assign pos_zero  = (position == '0);
	assign pos_m1    = position - POS_W'(1);
	assign ins_range = ({1'b0, position} > ((POS_W + 1)'(count_q) + (POS_W + 1)'(1)));
	assign del_range = ((POS_W + 1)'(position) > (POS_W + 1)'(count_q));

	always_comb begin
		ins_p = '0;
		del_p = '0;
		if (action == A_INS_TAIL) begin
			ins_p = count_q;
		end else if (action == A_INS_AT) begin
			ins_p = pos_m1[CNT_W-1:0];
		end
		if (action == A_DEL_TAIL) begin
			del_p = count_q - CNT_W'(1);
		end else if (action == A_DEL_AT) begin
			del_p = pos_m1[CNT_W-1:0];
		end
	end

	always_comb begin
		dec_emit   = 1'b0;
		dec_status = ST_OK;
		dec_state  = S_IDLE;
		dec_moves  = '0;
		dec_rd     = '0;
		dec_slot   = '0;
		unique case (action)
			A_INS_HEAD, A_INS_TAIL, A_INS_AT: begin
				if (action == A_INS_AT && pos_zero) begin
					dec_emit   = 1'b1;
					dec_status = ST_INVALID;
				end else if (full) begin
					dec_emit   = 1'b1;
					dec_status = ST_FULL;
				end else if (action == A_INS_AT && ins_range) begin
					dec_emit   = 1'b1;
					dec_status = ST_RANGE;
				end else begin
					// Move words from the top down to the slot, then write.
					dec_state = S_INS;
					dec_moves = count_q - ins_p;
					dec_rd    = ADDR_W'(count_q - CNT_W'(1));
					dec_slot  = ins_p[ADDR_W-1:0];
				end
			end
			A_DEL_HEAD, A_DEL_TAIL, A_DEL_AT: begin
				if (empty) begin
					dec_emit   = 1'b1;
					dec_status = ST_EMPTY;
				end else if (action == A_DEL_AT && pos_zero) begin
					dec_emit   = 1'b1;
					dec_status = ST_INVALID;
				end else if (action == A_DEL_AT && del_range) begin
					dec_emit   = 1'b1;
					dec_status = ST_RANGE;
				end else begin
					// Close the gap: move the words above the slot down by one.
					dec_state = S_DEL;
					dec_moves = count_q - CNT_W'(1) - del_p;
					dec_rd    = ADDR_W'(del_p + CNT_W'(1));
				end
			end
			A_READ_ALL: begin
				if (empty) begin
					dec_emit   = 1'b1;
					dec_status = ST_EMPTY;
				end else begin
					dec_state = S_DUMP;
					dec_moves = count_q;
				end
			end
			default: begin
				// Unused code: drop the command.
			end
		endcase
	end

	assign issue    = busy && (moves_q != '0);
	assign done     = busy && (moves_q == '0) && !pend_s1;
	assign dump_out = (state_q == S_DUMP) && pend_s1;

	// Write port: a moved word has priority; the new word goes in once the
	// shift has drained, which is the cycle that also ends the command.
	always_comb begin
		wr = '0;
		if (pend_s1 && state_q == S_INS) begin
			wr.en   = 1'b1;
			wr.addr = addr_s1 + ADDR_W'(1);
			wr.data = rd_data;
		end else if (pend_s1 && state_q == S_DEL) begin
			wr.en   = 1'b1;
			wr.addr = addr_s1 - ADDR_W'(1);
			wr.data = rd_data;
		end else if (done && state_q == S_INS) begin
			wr.en   = 1'b1;
			wr.addr = slot_q;
			wr.data = val_q;
		end
	end

	ple_ram u_ram (
		.clk     (clk),
		.wr      (wr),
		.rd_en   (issue),
		.rd_addr (rd_q),
		.rd_data (rd_data)
	);

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			moves_q  <= '0;
			pend_s1  <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			pend_s1  <= issue;
			strobe_q <= (accept && dec_emit) || dump_out || (done && state_q != S_DUMP);
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= dec_state;
						moves_q <= dec_moves;
					end
				end
				S_INS, S_DEL, S_DUMP: begin
					if (issue) begin
						moves_q <= moves_q - CNT_W'(1);
					end
					if (done) begin
						state_q <= S_IDLE;
						if (state_q == S_INS) begin
							count_q <= count_q + CNT_W'(1);
						end else if (state_q == S_DEL) begin
							count_q <= count_q - CNT_W'(1);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Addresses and payload: no reset needed.
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_q   <= dec_rd;
			slot_q <= dec_slot;
			val_q  <= value;
		end else if (issue) begin
			rd_q <= (state_q == S_INS) ? rd_q - ADDR_W'(1) : rd_q + ADDR_W'(1);
		end
		if (issue) begin
			addr_s1 <= rd_q;
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (accept && dec_emit) begin
			status_q    <= dec_status;
			value_res_q <= '0;
			index_q     <= '0;
			last_q      <= 1'b1;
		end else if (dump_out) begin
			status_q    <= ST_OK;
			value_res_q <= rd_data;
			index_q     <= IDX_W'(addr_s1);
			last_q      <= (moves_q == '0);
		end else if (done) begin
			status_q    <= ST_OK;
			value_res_q <= '0;
			index_q     <= '0;
			last_q      <= 1'b1;
		end
	end

	assign strobe    = strobe_q;
	assign status    = status_q;
	assign value_res = value_res_q;
	assign index     = index_q;
	assign last      = last_q;

endmodule

>>> hdl/ple_ram.sv
// Entry store: single write port, single registered read port.
`timescale 1ns / 1ps

module ple_ram (
	input  logic                        clk,
	input  ple_pkg::ram_wr_t            wr,
	input  logic                        rd_en,
	input  logic [ple_pkg::ADDR_W-1:0]  rd_addr,
	output logic [ple_pkg::VAL_W-1:0]   rd_data
);
	import ple_pkg::*;

	logic [VAL_W-1:0] mem [CAPACITY];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> hdl/ple_checker.sv
// Port-level checks on the positional list engine, bound to the top level.
`timescale 1ns / 1ps

module ple_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        busy,
	input  logic [ple_pkg::ACT_W-1:0]   action,
	input  logic [ple_pkg::VAL_W-1:0]   value,
	input  logic [ple_pkg::POS_W-1:0]   position,
	input  logic                        strobe,
	input  logic [ple_pkg::ST_W-1:0]    status,
	input  logic [ple_pkg::VAL_W-1:0]   value_res,
	input  logic [ple_pkg::IDX_W-1:0]   index,
	input  logic                        last
);
	import ple_pkg::*;

	// Any error word is a lone, final word with no payload.
	a_err_word: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && status != ST_OK |-> last && value_res == '0 && index == '0)
		else $error("error word carries payload or is not final");

	// A read-out streams without gaps, index climbing by one.
	a_stream: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |=> strobe && index == $past(index) + IDX_W'(1))
		else $error("read-out stream broken");

	// While more words are due the engine stays busy.
	a_busy_stream: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |-> busy)
		else $error("not busy during read-out");

	// A read-out either answers at once (empty) or holds the engine busy.
	a_read_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && action == A_READ_ALL |=> strobe || busy)
		else $error("read-out command neither answered nor started");

endmodule

bind positional_list_engine ple_checker u_ple_checker (.*);

>>> test/ple_checker.sv
// Checker for the positional list engine: list model, expected result words and comparison.
`timescale 1ns / 1ps

module ple_scoreboard
	import ple_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic                     busy,
	input  logic [ACT_W-1:0]         action,
	input  logic signed [VAL_W-1:0]  value,
	input  logic [POS_W-1:0]         position,
	input  logic                     strobe,
	input  logic [ST_W-1:0]          status,
	input  logic signed [VAL_W-1:0]  value_res,
	input  logic [IDX_W-1:0]         index,
	input  logic                     last,
	output int                       fail_count,
	output int                       pending,
	output int                       stored
);

	typedef struct {
		status_t                 st;
		logic signed [VAL_W-1:0] val;
		logic [IDX_W-1:0]        idx;
		logic                    lst;
	} reply_t;

	logic signed [VAL_W-1:0] list_words[$];
	reply_t                  reply_q[$];
	int                      mismatches = 0;

	function automatic void push_reply(status_t st, logic signed [VAL_W-1:0] val, int idx,
			logic lst);
		reply_t r;
		r.st  = st;
		r.val = val;
		r.idx = IDX_W'(idx);
		r.lst = lst;
		reply_q.push_back(r);
	endfunction

	// Update the list model for one accepted command word and queue its replies.
	function automatic void apply_command(logic [ACT_W-1:0] act, logic signed [VAL_W-1:0] val,
			logic [POS_W-1:0] pos);
		int      p;
		int      n;
		status_t st;
		p  = int'(pos);
		n  = list_words.size();
		st = ST_OK;
		case (act)
			A_INS_HEAD: begin
				if (n >= CAPACITY) st = ST_FULL;
				else list_words.push_front(val);
			end
			A_INS_TAIL: begin
				if (n >= CAPACITY) st = ST_FULL;
				else list_words.push_back(val);
			end
			A_INS_AT: begin
				if (p < 1) st = ST_INVALID;
				else if (n >= CAPACITY) st = ST_FULL;
				else if (p > n + 1) st = ST_RANGE;
				else list_words.insert(p - 1, val);
			end
			A_DEL_HEAD: begin
				if (n == 0) st = ST_EMPTY;
				else void'(list_words.pop_front());
			end
			A_DEL_TAIL: begin
				if (n == 0) st = ST_EMPTY;
				else void'(list_words.pop_back());
			end
			A_DEL_AT: begin
				if (n == 0) st = ST_EMPTY;
				else if (p < 1) st = ST_INVALID;
				else if (p > n) st = ST_RANGE;
				else list_words.delete(p - 1);
			end
			A_READ_ALL: begin
				if (n == 0) push_reply(ST_EMPTY, '0, 0, 1'b1);
				else for (int i = 0; i < n; i++) push_reply(ST_OK, list_words[i], i, i == n - 1);
				return;
			end
			default: return;
		endcase
		push_reply(st, '0, 0, 1'b1);
	endfunction

	function automatic void check_reply();
		reply_t r;
		if (reply_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: unexpected result word: status %0d value %0d index %0d last %0d",
					$time, status, value_res, index, last);
			return;
		end
		r = reply_q.pop_front();
		if (status !== r.st || value_res !== r.val || index !== r.idx || last !== r.lst) begin
			mismatches++;
			if (mismatches <= 10) begin
				$write("%0t: result word: expected status %0d value %0d index %0d last %0d",
					$time, r.st, r.val, r.idx, r.lst);
				$display(", got status %0d value %0d index %0d last %0d",
					status, value_res, index, last);
			end
		end
	endfunction

	// Compare first: a result word never belongs to a command taken at the same edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (strobe) check_reply();
			if (start && !busy) apply_command(action, value, position);
		end
		fail_count <= mismatches;
		pending    <= reply_q.size();
		stored     <= list_words.size();
	end

endmodule

>>> test/tb_positional_list_engine.sv
// Testbench top for the positional list engine: clock, reset, command stimulus and verdict.
`timescale 1ns / 1ps

module tb_positional_list_engine;
	import ple_pkg::*;

	// The one action code the block leaves unused; it must be dropped silently.
	localparam logic [ACT_W-1:0] A_UNUSED = 3'd7;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	logic [ACT_W-1:0]        action;
	logic signed [VAL_W-1:0] value;
	logic [POS_W-1:0]        position;
	logic                    strobe;
	logic [ST_W-1:0]         status;
	logic signed [VAL_W-1:0] value_res;
	logic [IDX_W-1:0]        index;
	logic                    last;
	int                      fail_count;
	int                      pending;
	int                      stored;

	// Set in the final stretch so that command words follow each other back to back.
	bit                      quiet = 1'b0;

	always #6 clk = ~clk;

	positional_list_engine dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.action    (action),
		.value     (value),
		.position  (position),
		.strobe    (strobe),
		.status    (status),
		.value_res (value_res),
		.index     (index),
		.last      (last)
	);

	// The checker watches both channels on its own and only hands back counts.
	ple_scoreboard u_scoreboard (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.action     (action),
		.value      (value),
		.position   (position),
		.strobe     (strobe),
		.status     (status),
		.value_res  (value_res),
		.index      (index),
		.last       (last),
		.fail_count (fail_count),
		.pending    (pending),
		.stored     (stored)
	);

	// Present one command word and hold it until the block takes it. Optionally drop
	// start for a random burst first, so that gaps land while the block is still
	// shifting, streaming or idle. Busy is read straight after the edge, which gives
	// the value the block itself saw at that edge.
	task automatic issue(logic [ACT_W-1:0] act, logic signed [VAL_W-1:0] val,
			logic [POS_W-1:0] pos);
		if (!quiet && $urandom_range(0, 99) < 25) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		start    <= 1'b1;
		action   <= act;
		value    <= val;
		position <= pos;
		do @(posedge clk); while (busy);
	endtask

	// Weighted choice of action: inserts, deletes, then read-outs and the odd unused code.
	function automatic logic [ACT_W-1:0] pick_action(int ins_pct, int del_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < ins_pct) return ACT_W'($urandom_range(A_INS_HEAD, A_INS_AT));
		if (r < ins_pct + del_pct) return ACT_W'($urandom_range(A_DEL_HEAD, A_DEL_AT));
		if (r < 96) return A_READ_ALL;
		return A_UNUSED;
	endfunction

	// Mostly a position that the current length accepts; otherwise zero or anything at
	// all. The length seen here may lag by one command, which only shifts the bias.
	function automatic logic [POS_W-1:0] pick_position();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return POS_W'($urandom_range(1, stored + 1));
		if (r < 80) return '0;
		return POS_W'($urandom_range(0, 255));
	endfunction

	task automatic random_phase(int words, int ins_pct, int del_pct);
		for (int i = 0; i < words; i++)
			issue(pick_action(ins_pct, del_pct), $urandom, pick_position());
	endtask

	initial begin
		int guard;
		arst_n   <= 1'b0;
		start    <= 1'b0;
		action   <= A_INS_HEAD;
		value    <= '0;
		position <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: every rejection on an empty list, the value extremes, both ends of
		// the position field, the unused code and a read-out before and after.
		issue(A_READ_ALL, '0, '0);
		issue(A_DEL_HEAD, '0, '0);
		issue(A_DEL_TAIL, '0, '0);
		issue(A_DEL_AT,   '0, 8'd0);    // empty wins over a bad position
		issue(A_INS_AT,   32'sd5, 8'd0);
		issue(A_INS_AT,   32'sd6, 8'd2);
		issue(A_INS_AT,   32'sh7fffffff, 8'd1);
		issue(A_INS_HEAD, 32'sh80000000, '0);
		issue(A_INS_TAIL, -32'sd1, '0);
		issue(A_INS_AT,   '0, 8'd2);
		issue(A_INS_AT,   32'sh5555aaaa, 8'd5);    // one past the end appends
		issue(A_READ_ALL, '0, '0);
		issue(A_DEL_AT,   '0, 8'd0);
		issue(A_DEL_AT,   '0, 8'd6);
		issue(A_INS_AT,   $urandom, 8'd255);
		issue(A_DEL_AT,   '0, 8'd255);
		issue(A_UNUSED,   $urandom, 8'd1);
		issue(A_DEL_AT,   '0, 8'd3);
		issue(A_DEL_HEAD, '0, '0);
		issue(A_DEL_TAIL, '0, '0);
		issue(A_READ_ALL, '0, '0);
		issue(A_DEL_AT,   '0, 8'd2);
		issue(A_DEL_AT,   '0, 8'd1);
		issue(A_READ_ALL, '0, '0);

		// Random: fill until the store refuses, drain until it is empty, then mix.
		// The last stretch runs with no gaps at all.
		random_phase(70, 85, 5);
		random_phase(70, 5, 85);
		random_phase(40, 42, 42);
		quiet = 1'b1;
		random_phase(40, 42, 42);

		// Drain: let the last read-out stream out, then give stragglers time to show.
		start <= 1'b0;
		@(posedge clk);
		guard = 0;
		while (pending != 0 && guard < 5000) begin
			@(posedge clk);
			guard++;
		end
		repeat (48) @(posedge clk);

		if (fail_count == 0 && pending == 0) begin
			$display("positional_list_engine: match");
		end else begin
			$display("positional_list_engine: mismatch");
		end
		$finish;
	end

	// Hard stop, well beyond the slowest legal run.
	initial begin
		#2_000_000;
		$display("positional_list_engine: mismatch");
		$finish;
	end

endmodule
